/* rtl/core/clfl_pkg.sv */
// Shared types and constants for the cell frequency link descriptor parser.
package clfl_pkg;

	localparam logic [7:0] SUB_BYTES     = 8'd5;
	localparam logic [2:0] LINK_LAST_POS = 3'd6;
	localparam logic [2:0] SUB_LAST_POS  = 3'd4;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LENGTH = 3'd1,
		PH_LINK   = 3'd2,
		PH_SUB    = 3'd3,
		PH_TAIL   = 3'd4,
		PH_SKIP   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		REC_LINK    = 2'd0,
		REC_SUBCELL = 2'd1,
		REC_END     = 2'd2
	} record_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} byte_word_t;

	typedef struct packed {
		record_kind_t record_kind;
		logic [15:0]  cell_id;
		logic [31:0]  frequency;
		logic [7:0]   cell_id_extension;
		logic         descriptor_done;
		logic         malformed;
	} rec_word_t;

endpackage

/* rtl/core/clfl_in_reg.sv */
// Input register: holds one descriptor byte until the parser consumes it.
module clfl_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  clfl_pkg::byte_word_t byte_data,
	input  logic                consume,
	output logic                valid_s1,
	output clfl_pkg::byte_word_t word_s1
);

	logic take;

	assign byte_stall = valid_s1 && !consume;
	assign take       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1 <= byte_data;
		end
	end

endmodule

/* rtl/core/clfl_parse.sv */
// Parse state machine: consumes one byte per cycle while the result register has room, and forms the result word.
module clfl_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  clfl_pkg::byte_word_t word_s1,
	input  logic                 room,
	output logic                 consume,
	output logic                 rec_load,
	output clfl_pkg::rec_word_t  rec_word
);

	clfl_pkg::phase_t phase_q, phase_d;
	logic [7:0]  desc_left_q, desc_left_d;
	logic [7:0]  sub_left_q, sub_left_d;
	logic [2:0]  fpos_q, fpos_d;
	logic [31:0] acc_q, acc_d;
	logic [15:0] cid_q, cid_d;
	logic [7:0]  ext_q, ext_d;
	logic        mal_q, mal_d;
	logic        emit;
	logic        last;
	logic [7:0]  b;
	logic [7:0]  dl;

	function automatic clfl_pkg::phase_t loop_phase(input logic [7:0] sub);
		if (sub == 8'd0) begin
			return clfl_pkg::PH_LINK;
		end else if (sub < clfl_pkg::SUB_BYTES) begin
			return clfl_pkg::PH_TAIL;
		end
		return clfl_pkg::PH_SUB;
	endfunction

	assign consume = valid_s1 && room;
	assign b       = word_s1.data_byte;
	assign dl      = desc_left_q - 8'd1;
	assign last    = (dl == 8'd0);

	always_comb begin
		phase_d     = phase_q;
		desc_left_d = desc_left_q;
		sub_left_d  = sub_left_q;
		fpos_d      = fpos_q;
		acc_d       = acc_q;
		cid_d       = cid_q;
		ext_d       = ext_q;
		mal_d       = mal_q;
		emit        = 1'b0;
		rec_word    = '0;
		rec_word.record_kind = clfl_pkg::REC_END;

		if (word_s1.first_byte) begin
			phase_d     = clfl_pkg::PH_LENGTH;
			desc_left_d = '0;
			sub_left_d  = '0;
			fpos_d      = '0;
			acc_d       = '0;
			cid_d       = '0;
			ext_d       = '0;
			mal_d       = 1'b0;
		end else begin
			case (phase_q)
				clfl_pkg::PH_IDLE: begin
				end
				clfl_pkg::PH_LENGTH: begin
					desc_left_d = b;
					fpos_d      = '0;
					if (b == 8'd0) begin
						phase_d                  = clfl_pkg::PH_IDLE;
						emit                     = 1'b1;
						rec_word.descriptor_done = 1'b1;
					end else begin
						phase_d = clfl_pkg::PH_LINK;
					end
				end
				clfl_pkg::PH_LINK, clfl_pkg::PH_SUB, clfl_pkg::PH_TAIL,
				clfl_pkg::PH_SKIP: begin
					desc_left_d = dl;
					if (phase_q == clfl_pkg::PH_LINK) begin
						if (fpos_q == 3'd0) begin
							cid_d = {b, 8'd0};
						end else if (fpos_q == 3'd1) begin
							cid_d = {cid_q[15:8], b};
						end else if (fpos_q < clfl_pkg::LINK_LAST_POS) begin
							acc_d = {acc_q[23:0], b};
						end
						if (fpos_q == clfl_pkg::LINK_LAST_POS) begin
							// loop length check against bytes still left
							if (b > dl) begin
								mal_d   = 1'b1;
								phase_d = clfl_pkg::PH_SKIP;
							end else begin
								sub_left_d = b;
								fpos_d     = '0;
								phase_d    = loop_phase(b);
								if (loop_phase(b) == clfl_pkg::PH_TAIL) begin
									mal_d = 1'b1;
								end
							end
							emit                     = 1'b1;
							rec_word.record_kind     = clfl_pkg::REC_LINK;
							rec_word.cell_id         = cid_q;
							rec_word.frequency       = acc_q;
							rec_word.descriptor_done = last;
						end else begin
							fpos_d = fpos_q + 3'd1;
							if (last) begin
								mal_d = 1'b1;
							end
						end
					end else if (phase_q == clfl_pkg::PH_SUB) begin
						sub_left_d = sub_left_q - 8'd1;
						if (fpos_q == 3'd0) begin
							ext_d = b;
						end else begin
							acc_d = {acc_q[23:0], b};
						end
						if (fpos_q == clfl_pkg::SUB_LAST_POS) begin
							fpos_d  = '0;
							phase_d = loop_phase(sub_left_d);
							if (loop_phase(sub_left_d) == clfl_pkg::PH_TAIL) begin
								mal_d = 1'b1;
							end
							emit                       = 1'b1;
							rec_word.record_kind       = clfl_pkg::REC_SUBCELL;
							rec_word.cell_id           = cid_q;
							rec_word.frequency         = acc_d;
							rec_word.cell_id_extension = ext_q;
							rec_word.descriptor_done   = last;
						end else begin
							fpos_d = fpos_q + 3'd1;
						end
					end else if (phase_q == clfl_pkg::PH_TAIL) begin
						// drop leftover loop bytes short of a full subcell
						if (sub_left_q != 8'd0) begin
							sub_left_d = sub_left_q - 8'd1;
						end
						if (sub_left_d == 8'd0) begin
							fpos_d  = '0;
							phase_d = clfl_pkg::PH_LINK;
						end
					end
					if (last) begin
						phase_d = clfl_pkg::PH_IDLE;
						if (!emit) begin
							emit                     = 1'b1;
							rec_word.descriptor_done = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
		rec_word.malformed = mal_d;
	end

	assign rec_load = consume && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= clfl_pkg::PH_IDLE;
			desc_left_q <= '0;
			sub_left_q  <= '0;
			fpos_q      <= '0;
			acc_q       <= '0;
			cid_q       <= '0;
			ext_q       <= '0;
			mal_q       <= 1'b0;
		end else if (consume) begin
			phase_q     <= phase_d;
			desc_left_q <= desc_left_d;
			sub_left_q  <= sub_left_d;
			fpos_q      <= fpos_d;
			acc_q       <= acc_d;
			cid_q       <= cid_d;
			ext_q       <= ext_d;
			mal_q       <= mal_d;
		end
	end

endmodule

/* rtl/core/clfl_out_reg.sv */
// Result register: holds one result word until the sink takes it.
module clfl_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  clfl_pkg::rec_word_t word,
	output logic                room,
	output logic                rec_valid,
	input  logic                rec_stall,
	output clfl_pkg::rec_word_t rec_data
);

	assign room = !rec_valid || !rec_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid <= 1'b0;
		end else if (load) begin
			rec_valid <= 1'b1;
		end else if (room) begin
			rec_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_data <= word;
		end
	end

endmodule

/* rtl/core/cell_frequency_link_parser.sv */
// Top level of the cell frequency link descriptor parser.
//
//  channel | ports                              | word
//  --------+------------------------------------+---------------------------
//  bytes   | byte_valid, byte_stall, byte_data  | data_byte, first_byte
//  records | rec_valid, rec_stall, rec_data     | kind, ids, frequency, flags
//
// One byte per cycle sustained while rec_stall stays low; a result reaches the outputs
// after its byte passes the input register, then parse logic into the result register.
// The parse state machine updates once per consumed byte, set by its single
// state register loop.
// Reset clears the valid bits and the parse state; the parser then waits for
// a byte marked first_byte. byte_stall rises only while a result is stalled.
module cell_frequency_link_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  clfl_pkg::byte_word_t byte_data,
	output logic                 rec_valid,
	input  logic                 rec_stall,
	output clfl_pkg::rec_word_t  rec_data
);

	logic                 valid_s1;
	clfl_pkg::byte_word_t word_s1;
	logic                 consume;
	logic                 room;
	logic                 rec_load;
	clfl_pkg::rec_word_t  rec_word;

	clfl_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.consume    (consume),
		.valid_s1   (valid_s1),
		.word_s1    (word_s1)
	);

	clfl_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1),
		.room     (room),
		.consume  (consume),
		.rec_load (rec_load),
		.rec_word (rec_word)
	);

	clfl_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (rec_load),
		.word      (rec_word),
		.room      (room),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_data  (rec_data)
	);

endmodule

/* rtl/core/clfl_checker.sv */
// Port-level checks for the cell frequency link descriptor parser.
module clfl_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 byte_valid,
	input logic                 byte_stall,
	input clfl_pkg::byte_word_t byte_data,
	input logic                 rec_valid,
	input logic                 rec_stall,
	input clfl_pkg::rec_word_t  rec_data
);

	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_stall |=> rec_valid && $stable(rec_data))
		else $error("stalled result word changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> rec_valid && rec_stall)
		else $error("byte stall without a blocked result");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_data.record_kind == clfl_pkg::REC_END |->
		rec_data.descriptor_done && rec_data.cell_id == 16'd0 &&
		rec_data.frequency == 32'd0 && rec_data.cell_id_extension == 8'd0)
		else $error("end-only result with stray fields");

	a_link_ext: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_data.record_kind == clfl_pkg::REC_LINK |->
		rec_data.cell_id_extension == 8'd0)
		else $error("link result carries an extension");

	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(byte_data))
		else $error("stalled byte word changed");

endmodule

bind cell_frequency_link_parser clfl_checker u_clfl_checker (.*);

/* sim/clfl_record_checker.sv */
// Record checker: tracks the byte stream, predicts each parser record and compares it.
module clfl_record_checker
	import clfl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic       byte_stall,
	input  byte_word_t byte_data,
	input  logic       rec_valid,
	input  logic       rec_stall,
	input  rec_word_t  rec_data,
	output int         fail_count,
	output int         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	phase_t      phase;
	logic [7:0]  desc_left;
	logic [7:0]  loop_left;
	logic [2:0]  pos;
	logic [31:0] freq_shift;
	logic [15:0] link_id;
	logic [7:0]  sub_ext;
	logic        bad_desc;

	rec_word_t   due_records[$];

	function automatic void clear_parse();
		phase      = PH_IDLE;
		desc_left  = '0;
		loop_left  = '0;
		pos        = '0;
		freq_shift = '0;
		link_id    = '0;
		sub_ext    = '0;
		bad_desc   = 1'b0;
	endfunction

	// A loop remainder under one subcell is dropped as malformed.
	function automatic void open_subcells();
		pos = '0;
		if (loop_left == 8'd0) begin
			phase = PH_LINK;
		end else if (loop_left < SUB_BYTES) begin
			phase    = PH_TAIL;
			bad_desc = 1'b1;
		end else begin
			phase = PH_SUB;
		end
	endfunction

	function automatic void add_record(record_kind_t kind, logic [15:0] cid,
			logic [31:0] freq, logic [7:0] ext, logic done);
		rec_word_t r;
		r.record_kind       = kind;
		r.cell_id           = cid;
		r.frequency         = freq;
		r.cell_id_extension = ext;
		r.descriptor_done   = done;
		r.malformed         = bad_desc;
		due_records = {due_records, r};
	endfunction

	function automatic void parse_byte(byte_word_t w);
		logic [7:0] b;
		logic       last;
		logic       made;
		b    = w.data_byte;
		made = 1'b0;
		if (w.first_byte) begin
			clear_parse();
			phase = PH_LENGTH;
			return;
		end
		if (phase == PH_IDLE || phase > PH_SKIP)
			return;
		if (phase == PH_LENGTH) begin
			desc_left = b;
			if (b == 8'd0) begin
				phase = PH_IDLE;
				add_record(REC_END, '0, '0, '0, 1'b1);
			end else begin
				phase = PH_LINK;
				pos   = '0;
			end
			return;
		end

		desc_left = desc_left - 8'd1;
		last      = (desc_left == 8'd0);

		case (phase)
			PH_LINK: begin
				if (pos == 3'd0)
					link_id = {b, 8'h00};
				else if (pos == 3'd1)
					link_id = link_id | {8'h00, b};
				else if (pos < LINK_LAST_POS)
					freq_shift = {freq_shift[23:0], b};
				if (pos == LINK_LAST_POS) begin
					if (b > desc_left) begin
						bad_desc = 1'b1;
						phase    = PH_SKIP;
					end else begin
						loop_left = b;
						open_subcells();
					end
					add_record(REC_LINK, link_id, freq_shift, '0, last);
					made = 1'b1;
				end else begin
					pos = pos + 3'd1;
					if (last)
						bad_desc = 1'b1;
				end
			end
			PH_SUB: begin
				loop_left = loop_left - 8'd1;
				if (pos == 3'd0)
					sub_ext = b;
				else
					freq_shift = {freq_shift[23:0], b};
				if (pos == SUB_LAST_POS) begin
					open_subcells();
					add_record(REC_SUBCELL, link_id, freq_shift, sub_ext, last);
					made = 1'b1;
				end else begin
					pos = pos + 3'd1;
				end
			end
			PH_TAIL: begin
				if (loop_left != 8'd0)
					loop_left = loop_left - 8'd1;
				if (loop_left == 8'd0)
					open_subcells();
			end
			default: begin
			end
		endcase

		if (last) begin
			phase = PH_IDLE;
			if (!made)
				add_record(REC_END, '0, '0, '0, 1'b1);
		end
	endfunction

	function automatic void note_mismatch(string what, rec_word_t want, rec_word_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t record mismatch (%s):", $realtime, what,
				" want kind %0d id %h freq %h ext %h done %b bad %b,",
				want.record_kind, want.cell_id, want.frequency,
				want.cell_id_extension, want.descriptor_done, want.malformed,
				" got kind %0d id %h freq %h ext %h done %b bad %b",
				got.record_kind, got.cell_id, got.frequency,
				got.cell_id_extension, got.descriptor_done, got.malformed);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rec_word_t want;
		string     diff;
		if (!arst_n) begin
			clear_parse();
			due_records.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (byte_valid && !byte_stall)
				parse_byte(byte_data);
			if (rec_valid && !rec_stall) begin
				if (due_records.size() == 0) begin
					note_mismatch("no record due", '0, rec_data);
				end else begin
					want = due_records.pop_front();
					diff = "";
					if (rec_data.record_kind !== want.record_kind)
						diff = {diff, " kind"};
					if (rec_data.cell_id !== want.cell_id)
						diff = {diff, " cell_id"};
					if (rec_data.frequency !== want.frequency)
						diff = {diff, " frequency"};
					if (rec_data.cell_id_extension !== want.cell_id_extension)
						diff = {diff, " extension"};
					if (rec_data.descriptor_done !== want.descriptor_done)
						diff = {diff, " done"};
					if (rec_data.malformed !== want.malformed)
						diff = {diff, " malformed"};
					if (diff != "")
						note_mismatch(diff, want, rec_data);
				end
			end
			outstanding = due_records.size();
		end
	end

endmodule

/* sim/cell_frequency_link_parser_test.sv */
// Top of the parser testbench: clock, reset, descriptor stimulus and the verdict.
module cell_frequency_link_parser_test;
	timeunit 1ns;
	timeprecision 1ps;
	import clfl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	byte_word_t byte_data  = '0;
	logic       rec_valid;
	logic       rec_stall  = 1'b0;
	rec_word_t  rec_data;

	int         fail_count;
	int         outstanding;
	int         cycle_count = 0;
	int         words_sent  = 0;
	logic       calm        = 1'b0;

	logic [7:0] body[$];
	int         loop_at;

	cell_frequency_link_parser DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec_data   (rec_data)
	);

	clfl_record_checker record_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_data   (byte_data),
		.rec_valid   (rec_valid),
		.rec_stall   (rec_stall),
		.rec_data    (rec_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		rec_stall <= !calm && ($urandom_range(99) < 20);
	end

	// Hold each word until the parser takes it; idle now and then before it.
	task automatic send_byte(input logic [7:0] b, input logic first, input logic tally);
		while (!calm && $urandom_range(99) < 20) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid          <= 1'b1;
		byte_data.data_byte  <= b;
		byte_data.first_byte <= first;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		@(negedge clk);
		if (tally)
			words_sent++;
	endtask

	task automatic send_descriptor(input logic [7:0] len_byte, input int count);
		send_byte(8'($urandom), 1'b1, 1'b1);
		send_byte(len_byte, 1'b0, 1'b1);
		for (int i = 0; i < count; i++)
			send_byte(body[i], 1'b0, 1'b1);
	endtask

	// Append one link: id, frequency, loop length, subcells, then filler bytes.
	function automatic void add_link(input int n_sub, input int extra);
		logic [31:0] word;
		word = $urandom;
		body = {body, word[15:8]};
		body = {body, word[7:0]};
		word = $urandom;
		for (int k = 3; k >= 0; k--)
			body = {body, word[k*8 +: 8]};
		loop_at = body.size();
		body = {body, 8'(5 * n_sub + extra)};
		repeat (n_sub) begin
			body = {body, 8'($urandom)};
			word = $urandom;
			for (int k = 3; k >= 0; k--)
				body = {body, word[k*8 +: 8]};
		end
		repeat (extra)
			body = {body, 8'($urandom)};
	endfunction

	initial begin
		int         mode;
		int         n_links;
		int         n_sub;
		int         extra;
		int         count;
		logic [7:0] len_byte;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// stray word before any tag, then an empty descriptor
		send_byte(8'hFF, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b1, 1'b1);
		send_byte(8'h00, 1'b0, 1'b1);
		// all-ones link with one subcell; the subcell closes the descriptor
		body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h05,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_byte(8'h00, 1'b1, 1'b1);
		send_byte(8'd12, 1'b0, 1'b1);
		for (int i = 0; i < 12; i++)
			send_byte(body[i], 1'b0, 1'b1);
		// descriptor ends inside a link header
		body = '{8'h00, 8'h80};
		send_descriptor(8'd2, 2);
		// loop length runs past the descriptor
		body = '{8'h12, 8'h34, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01};
		send_descriptor(8'd7, 7);

		words_sent = 0;
		while (words_sent < 850) begin
			calm    <= (words_sent >= 300 && words_sent < 450);
			mode    = $urandom_range(99);
			loop_at = -1;
			body.delete();
			if ($urandom_range(39) == 0) begin
				add_link(49, 3);
			end else begin
				n_links = $urandom_range(0, 3);
				repeat (n_links) begin
					n_sub = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 3);
					extra = (mode >= 70 && mode < 78 && $urandom_range(1) == 0) ?
						$urandom_range(1, 4) : 0;
					add_link(n_sub, extra);
				end
			end
			len_byte = 8'(body.size());
			count    = body.size();
			if (mode >= 78 && mode < 86 && loop_at >= 0) begin
				body[loop_at] = 8'($urandom_range(body.size() - loop_at, 255));
			end else if (mode >= 86 && mode < 93 && count > 0) begin
				len_byte = 8'($urandom_range(0, count - 1));
				count    = len_byte;
			end else if (mode >= 93 && mode < 97 && count > 0) begin
				// drop the tail; the next tag restarts the parse
				count = $urandom_range(0, count - 1);
			end
			if (mode >= 97) begin
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom), 1'b0, 1'b0);
			end else begin
				send_descriptor(len_byte, count);
			end
		end
		byte_valid <= 1'b0;
		calm       <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
